// ===== sv/ubx_fp_pkg.sv =====
// Shared types, constants and a helper function for the UBX frame parser.
package ubx_fp_pkg;

    localparam int MAX_PAYLOAD = 1024;
    localparam int CAP_W       = 11;
    localparam int POS_W       = 11;
    localparam int SKIP_W      = 17;
    localparam int IDX_W       = 10;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [1:0] ST_PROGRESS = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_CKERR    = 2'd2;
    localparam logic [1:0] ST_OVERSIZE = 2'd3;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B,
        PH_SKIP
    } phase_t;

    // Per-frame bookkeeping; cleared as a whole at sync and at frame end.
    typedef struct packed {
        logic [7:0]        held_class;
        logic [7:0]        held_id;
        logic [15:0]       held_length;
        logic [POS_W-1:0]  byte_position;
        logic [7:0]        sum_a;
        logic [7:0]        sum_b;
        logic [7:0]        got_sum_a;
        logic [SKIP_W-1:0] skip_count;
    } frame_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       msg_class;
        logic [7:0]       msg_id;
        logic [15:0]      frame_length;
        logic             payload_valid;
        logic [IDX_W-1:0] payload_offset;
        logic [7:0]       payload_data;
    } result_t;

    function automatic logic [CAP_W-1:0] clamp_capacity(input logic [CAP_W-1:0] v);
        logic [CAP_W-1:0] c;
        c = v;
        if (32'(v) > MAX_PAYLOAD)
        begin
            c = CAP_W'(MAX_PAYLOAD);
        end
        return c;
    endfunction

    localparam logic [CAP_W-1:0] CAP_RESET = clamp_capacity(CAP_W'(1024));

endpackage

// ===== sv/ubx_frame_parser.sv =====
// Top level of the UBX frame parser: input register, capacity register, core, result register.
//
//  Channel   Handshake              Carries
//  --------  ---------------------  ------------------------------------------------
//  input     in_valid / in_ready    rx_byte
//  output    out_valid / out_ready  status, msg_class, msg_id, frame_length,
//                                   payload_valid, payload_offset, payload_data
//  config    cfg_we                 cfg_wdata (capacity limit)
//
// One byte per clock is sustained while the output is not stalled: each request is registered in
// the input register, then the state machine update and the result are formed from it and captured
// in the result register.
// Reset puts the parser in the hunt for the first sync byte, capacity 1024.
// A stalled output holds the input register, and new requests are refused only while both
// the input register and the result register are full.
module ubx_frame_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [7:0]                       msg_class,
    output logic [7:0]                       msg_id,
    output logic [15:0]                      frame_length,
    output logic                             payload_valid,
    output logic [ubx_fp_pkg::IDX_W-1:0]     payload_offset,
    output logic [7:0]                       payload_data,
    input  logic                             cfg_we,
    input  logic [ubx_fp_pkg::CAP_W-1:0]     cfg_wdata
);
    import ubx_fp_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg, in_byte_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             step_en;
    logic             in_accept;
    result_t          core_result;
    result_t          out_result;

    // The held byte is processed whenever the result register can take its result.
    assign step_en   = in_valid_reg && (!out_valid || out_ready);
    assign in_ready  = !in_valid_reg || step_en;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = rx_byte;
        end
        else if (step_en)
        begin
            in_valid_next = 1'b0;
        end
        cap_next = cfg_we ? clamp_capacity(cfg_wdata) : cap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cap_reg      <= CAP_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cap_reg      <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
    end

    ubx_fp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step_en),
        .rx_byte  (in_byte_reg),
        .capacity (cap_reg),
        .result   (core_result)
    );

    ubx_fp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step_en),
        .result_in  (core_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (out_result)
    );

    assign status         = out_result.status;
    assign msg_class      = out_result.msg_class;
    assign msg_id         = out_result.msg_id;
    assign frame_length   = out_result.frame_length;
    assign payload_valid  = out_result.payload_valid;
    assign payload_offset = out_result.payload_offset;
    assign payload_data   = out_result.payload_data;

    // An empty result register must never block a new request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused while result register empty");

    // Payload bytes are only ever reported while a frame is in progress.
    a_payload_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && payload_valid) |-> (status == ST_PROGRESS))
        else $error("payload byte reported with a final status");

    // Frame fields are zero unless the frame completed.
    a_fields_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_COMPLETE) |->
        (msg_class == 8'd0 && msg_id == 8'd0 && frame_length == 16'd0))
        else $error("frame fields set without a complete frame");

    // A result is held until the consumer takes it.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_result)))
        else $error("stalled result changed");

endmodule

// ===== sv/ubx_fp_core.sv =====
// Parser state machine: frame state registers and the per-byte update logic.
module ubx_fp_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step_en,
    input  logic [7:0]                     rx_byte,
    input  logic [ubx_fp_pkg::CAP_W-1:0]   capacity,
    output ubx_fp_pkg::result_t            result
);
    import ubx_fp_pkg::*;

    phase_t phase_reg, phase_next;
    frame_t frame_reg, frame_next;

    logic [7:0]        sum_a_upd;
    logic [7:0]        sum_b_upd;
    logic [15:0]       len_full;
    logic [POS_W-1:0]  pos_plus;
    logic [SKIP_W-1:0] skip_dec;

    // Fletcher-8 running sums with the current byte folded in.
    assign sum_a_upd = frame_reg.sum_a + rx_byte;
    assign sum_b_upd = frame_reg.sum_b + sum_a_upd;
    assign len_full  = {rx_byte, frame_reg.held_length[7:0]};
    assign pos_plus  = frame_reg.byte_position + POS_W'(1);
    assign skip_dec  = (frame_reg.skip_count != '0) ?
                       frame_reg.skip_count - SKIP_W'(1) : '0;

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        frame_next = frame_reg;
        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (rx_byte == SYNC_FIRST)
                begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    frame_next = '0;
                    phase_next = PH_CLASS;
                end
                else if (rx_byte != SYNC_FIRST)
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_CLASS:
            begin
                frame_next.held_class = rx_byte;
                frame_next.sum_a      = sum_a_upd;
                frame_next.sum_b      = sum_b_upd;
                phase_next            = PH_ID;
            end
            PH_ID:
            begin
                frame_next.held_id = rx_byte;
                frame_next.sum_a   = sum_a_upd;
                frame_next.sum_b   = sum_b_upd;
                phase_next         = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                frame_next.held_length = {8'd0, rx_byte};
                frame_next.sum_a       = sum_a_upd;
                frame_next.sum_b       = sum_b_upd;
                phase_next             = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                frame_next.held_length = len_full;
                frame_next.sum_a       = sum_a_upd;
                frame_next.sum_b       = sum_b_upd;
                if (len_full > 16'(capacity))
                begin
                    frame_next.skip_count = {1'b0, len_full} + SKIP_W'(2);
                    phase_next            = PH_SKIP;
                end
                else if (len_full == 16'd0)
                begin
                    phase_next = PH_CK_A;
                end
                else
                begin
                    frame_next.byte_position = '0;
                    phase_next               = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                frame_next.sum_a         = sum_a_upd;
                frame_next.sum_b         = sum_b_upd;
                frame_next.byte_position = pos_plus;
                if (16'(pos_plus) >= frame_reg.held_length)
                begin
                    phase_next = PH_CK_A;
                end
            end
            PH_CK_A:
            begin
                frame_next.got_sum_a = rx_byte;
                phase_next           = PH_CK_B;
            end
            PH_CK_B:
            begin
                frame_next = '0;
                phase_next = PH_SYNC1;
            end
            PH_SKIP:
            begin
                frame_next.skip_count = skip_dec;
                if (skip_dec == '0)
                begin
                    frame_next = '0;
                    phase_next = PH_SYNC1;
                end
            end
            default:
            begin
                frame_next = '0;
                phase_next = PH_SYNC1;
            end
        endcase
    end

    // Result for the current byte.
    always_comb
    begin
        result = '0;
        unique case (phase_reg)
            PH_LEN_HI:
            begin
                if (len_full > 16'(capacity))
                begin
                    result.status = ST_OVERSIZE;
                end
            end
            PH_PAYLOAD:
            begin
                result.payload_valid  = 1'b1;
                result.payload_offset = frame_reg.byte_position[IDX_W-1:0];
                result.payload_data   = rx_byte;
            end
            PH_CK_B:
            begin
                if (frame_reg.got_sum_a == frame_reg.sum_a && rx_byte == frame_reg.sum_b)
                begin
                    result.status       = ST_COMPLETE;
                    result.msg_class    = frame_reg.held_class;
                    result.msg_id       = frame_reg.held_id;
                    result.frame_length = frame_reg.held_length;
                end
                else
                begin
                    result.status = ST_CKERR;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            frame_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            frame_reg <= frame_next;
        end
    end

endmodule

// ===== sv/ubx_fp_out_stage.sv =====
// Result register with valid/ready handshake toward the consumer.
module ubx_fp_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ubx_fp_pkg::result_t result_in,
    output logic                out_valid,
    input  logic                out_ready,
    output ubx_fp_pkg::result_t result_out
);
    import ubx_fp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = result_in;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule
